>>> design/four_register_eight_bit_cpu_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-register eight-bit CPU
// Each macro takes a label, an antecedent and a consequent; the clock is clk
// and the check is off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_REGISTER_EIGHT_BIT_CPU_MACROS_SVH
`define FOUR_REGISTER_EIGHT_BIT_CPU_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle
`define FRC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");
// Consequent must hold in the following cycle
`define FRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");
`else
`define FRC_ASSERT_SAME(lbl, ante, cons)
`define FRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and codes for the four-register eight-bit CPU: command and
// opcode codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package frc_pkg;

	// Item commands
	localparam logic [1:0] CMD_LOAD    = 2'b00;
	localparam logic [1:0] CMD_RESTART = 2'b01;
	localparam logic [1:0] CMD_STEP    = 2'b10;

	// Instruction opcodes, bits 7..6 of the instruction byte
	localparam logic [1:0] OP_ADD = 2'b00;
	localparam logic [1:0] OP_OUT = 2'b01;
	localparam logic [1:0] OP_LI  = 2'b10;
	localparam logic [1:0] OP_BNE = 2'b11;

	localparam int unsigned STORE_DEPTH = 16;
	localparam int unsigned RF_DEPTH    = 4;
	localparam logic [7:0]  START_RESET = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_RD_A,
		ST_RD_B,
		ST_RD_Z,
		ST_EXEC,
		ST_DONE
	} frc_state_t;

	// Register file read address select
	typedef enum logic [1:0] {
		RSEL_A,
		RSEL_B,
		RSEL_ZERO
	} frc_rsel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      store_we;
		logic      restart;
		logic      clear_res;
		logic      fetch;
		frc_rsel_t rsel;
		logic      cap_a;
		logic      cap_b;
		logic      exec;
		logic      load_out;
	} frc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic halted;
	} frc_sts_t;

endpackage

>>> design/frc_ctrl.sv
// ----------------------------------------------------------------------------
// frc_ctrl
// Controller state machine: takes items, sequences fetch, register reads
// and execute, and owns the result handshake.
// ----------------------------------------------------------------------------
`include "four_register_eight_bit_cpu_macros.svh"

module frc_ctrl import frc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	output logic       res_valid,
	input  logic       res_ready,
	input  frc_sts_t   sts,
	output frc_cmd_t   cmd
);

	frc_state_t state_q;
	frc_state_t state_nxt;
	logic       res_valid_q;
	logic       out_free;

	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			res_valid_q <= cmd.load_out || (res_valid_q && !res_ready);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_STEP && !sts.halted) state_nxt = ST_FETCH;
					else state_nxt = ST_DONE;
				end
			end
			ST_FETCH: state_nxt = ST_RD_A;
			ST_RD_A:  state_nxt = ST_RD_B;
			ST_RD_B:  state_nxt = ST_RD_Z;
			ST_RD_Z:  state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		cmd.rsel = RSEL_A;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.clear_res = 1'b1;
					cmd.store_we  = (command == CMD_LOAD);
					cmd.restart   = (command == CMD_RESTART);
				end
			end
			ST_FETCH: cmd.fetch = 1'b1;
			ST_RD_A:  cmd.rsel = RSEL_A;
			ST_RD_B: begin
				cmd.rsel  = RSEL_B;
				cmd.cap_a = 1'b1;
			end
			ST_RD_Z: begin
				cmd.rsel  = RSEL_ZERO;
				cmd.cap_b = 1'b1;
			end
			ST_EXEC:  cmd.exec = 1'b1;
			ST_DONE:  cmd.load_out = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Checks
	`FRC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`FRC_ASSERT_SAME(a_load_out_free, cmd.load_out, !res_valid_q || res_ready)
	`FRC_ASSERT_SAME(a_no_fetch_halted, state_q == ST_FETCH, !sts.halted)
	`FRC_ASSERT_NEXT(a_exec_then_done, cmd.exec, state_q == ST_DONE)

endmodule

>>> design/frc_dp.sv
// ----------------------------------------------------------------------------
// frc_dp
// Datapath: program store, register file with one registered read port,
// program counter, operand registers, adder, branch compare and the result
// register.
// ----------------------------------------------------------------------------
module frc_dp import frc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  frc_cmd_t   cmd,
	output frc_sts_t   sts,
	input  logic       cfg_valid,
	input  logic [7:0] cfg_data,
	input  logic [3:0] load_address,
	input  logic [7:0] load_data,
	output logic       out_valid,
	output logic [1:0] out_index,
	output logic [7:0] out_value,
	output logic [4:0] next_address,
	output logic       halted
);

	logic [7:0] prog_mem [STORE_DEPTH];
	logic [7:0] rf_mem [RF_DEPTH];
	logic [RF_DEPTH-1:0] rf_vld_q;

	logic [7:0] start_q;
	logic [4:0] pc_q;
	logic [7:0] instr_q;
	logic [7:0] rf_rd_q;
	logic [7:0] opa_q;
	logic [7:0] opb_q;
	logic       shown_q;
	logic [1:0] idx_q;
	logic [7:0] val_q;

	logic [1:0] op;
	logic [1:0] dst;
	logic [1:0] srca;
	logic [1:0] srcb;
	logic [1:0] raddr;
	logic       rf_we;
	logic [1:0] rf_waddr;
	logic [7:0] rf_wdata;
	logic [4:0] pc_nxt;

	logic       out_valid_q;
	logic [1:0] out_index_q;
	logic [7:0] out_value_q;
	logic [4:0] next_address_q;
	logic       halted_q;

	assign op   = instr_q[7:6];
	assign dst  = instr_q[5:4];
	assign srca = instr_q[3:2];
	assign srcb = instr_q[1:0];

	assign sts.halted = pc_q[4];

	// Select register read address
	always_comb begin
		case (cmd.rsel)
			RSEL_A:    raddr = srca;
			RSEL_B:    raddr = srcb;
			RSEL_ZERO: raddr = 2'd0;
			default:   raddr = 2'd0;
		endcase
	end

	// Register write port and next program counter
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = dst;
		rf_wdata = opa_q + opb_q;
		pc_nxt   = pc_q + 5'd1;
		if (cmd.restart) begin
			rf_we    = 1'b1;
			rf_waddr = 2'd0;
			rf_wdata = start_q;
		end else if (cmd.exec) begin
			case (op)
				OP_ADD: rf_we = 1'b1;
				OP_LI: begin
					rf_we    = 1'b1;
					rf_wdata = {4'b0000, instr_q[3:0]};
				end
				OP_BNE: begin
					// rf_rd_q holds R0 here
					if (rf_rd_q != opb_q) pc_nxt = {1'b0, instr_q[5:2]};
				end
				default: rf_we = 1'b0;
			endcase
		end
	end

	// Program store: write on load, registered read at the program counter
	always_ff @(posedge clk) begin
		if (cmd.store_we) prog_mem[load_address] <= load_data;
		if (cmd.fetch) instr_q <= prog_mem[pc_q[3:0]];
	end

	// Register file storage and registered read; invalid entries read zero
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
		rf_rd_q <= rf_vld_q[raddr] ? rf_mem[raddr] : 8'd0;
	end

	// Capture operands
	always_ff @(posedge clk) begin
		if (cmd.cap_a) opa_q <= rf_rd_q;
		if (cmd.cap_b) opb_q <= rf_rd_q;
	end

	// Control registers: start value, program counter, register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RESET;
			pc_q     <= '0;
			rf_vld_q <= '0;
		end else begin
			if (cfg_valid) start_q <= cfg_data;
			if (cmd.restart) begin
				pc_q     <= '0;
				rf_vld_q <= {{(RF_DEPTH-1){1'b0}}, 1'b1};
			end else begin
				if (cmd.exec) pc_q <= pc_nxt;
				if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
			end
		end
	end

	// Hold the out-instruction report for this item
	always_ff @(posedge clk) begin
		if (cmd.clear_res) begin
			shown_q <= 1'b0;
			idx_q   <= 2'd0;
			val_q   <= 8'd0;
		end else if (cmd.exec && op == OP_OUT) begin
			shown_q <= 1'b1;
			idx_q   <= srca;
			val_q   <= opa_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_valid_q    <= shown_q;
			out_index_q    <= idx_q;
			out_value_q    <= val_q;
			next_address_q <= pc_q;
			halted_q       <= pc_q[4];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_index    = out_index_q;
	assign out_value    = out_value_q;
	assign next_address = next_address_q;
	assign halted       = halted_q;

endmodule

>>> design/four_register_eight_bit_cpu.sv
// ----------------------------------------------------------------------------
// four_register_eight_bit_cpu
// Minimal four-instruction processor with a 16-byte program store.
// ----------------------------------------------------------------------------
// Each item is a load (write one program byte), a restart (clear PC and
// registers, R0 takes start_value) or a step (run one instruction), and each
// yields exactly one result item carrying the out-instruction report, the
// program counter after the item and the halted flag. One item is in work at
// a time: load, restart, unused commands and a step while halted go from
// acceptance straight to the result, and a step passes through fetch, three
// reads through the register file's single read port, execute and result.
// The result sits in an output register, so a new item is taken as soon as
// the previous result is registered, even while it waits to be taken.
// start_value may be written on the cfg port at any cycle; it is always ready.
// ----------------------------------------------------------------------------
module four_register_eight_bit_cpu import frc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [3:0] load_address,
	input  logic [7:0] load_data,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       out_valid,
	output logic [1:0] out_index,
	output logic [7:0] out_value,
	output logic [4:0] next_address,
	output logic       halted
);

	frc_cmd_t cmd;
	frc_sts_t sts;

	assign cfg_ready = 1'b1;

	frc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	frc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.load_address (load_address),
		.load_data    (load_data),
		.out_valid    (out_valid),
		.out_index    (out_index),
		.out_value    (out_value),
		.next_address (next_address),
		.halted       (halted)
	);

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for four_register_eight_bit_cpu
// Runs a short table of hand-picked items (start value 255, every
// opcode, wrapping add, taken and untaken branches, halt, the unused
// command, loads while halted), then random programs: load the store,
// restart, step a random number of times, with stray loads, restarts and
// unused commands mixed in. Every result is checked against the table's
// expected value or a cycle-free predictor of the processor in this file.
// ----------------------------------------------------------------------------
module tb import frc_pkg::*;;

	localparam logic [1:0] CMD_UNUSED  = 2'b11;
	localparam logic [4:0] HALT_PC     = 5'd16;
	localparam int         HOLD_CYCLES = 80;
	localparam int         DRAIN_LIMIT = 2000;
	localparam int         SETTLE      = 10;
	localparam int         DIR_ROWS    = 22;
	localparam int         PHASE_ITEMS = 365;

	typedef struct packed {
		logic       out_valid;
		logic [1:0] out_index;
		logic [7:0] out_value;
		logic [4:0] next_address;
		logic       halted;
	} cpu_result_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  addr;
		logic [7:0]  data;
		logic        typed;
		cpu_result_t want;
	} stim_row_t;

	// Results read straight off the spec; DERIVED rows come from the predictor
	localparam cpu_result_t DERIVED      = '0;
	localparam cpu_result_t RES_PC0      = '{1'b0, 2'd0, 8'h00, 5'd0, 1'b0};
	localparam cpu_result_t RES_HALTED   = '{1'b0, 2'd0, 8'h00, 5'd16, 1'b1};
	localparam cpu_result_t RES_OUT_R0FF = '{1'b1, 2'd0, 8'hFF, 5'd16, 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] command = CMD_LOAD;
	logic [3:0] load_address = 4'h0;
	logic [7:0] load_data = 8'h00;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic       out_valid;
	logic [1:0] out_index;
	logic [7:0] out_value;
	logic [4:0] next_address;
	logic       halted;

	// Predictor state
	logic [7:0] prog_mem [STORE_DEPTH];
	logic       prog_written [STORE_DEPTH];
	logic [7:0] gpr [RF_DEPTH];
	logic [4:0] pc;
	logic [7:0] start_val;

	cpu_result_t expected_q [$];

	bit quiet = 1'b0;
	bit hold_pending = 1'b0;
	int failures = 0;
	int n_load = 0, n_restart = 0, n_step = 0, n_unused = 0;
	int results_seen = 0, out_reports = 0, halted_seen = 0;
	int start_writes = 0, holds_done = 0;

	// Table: restart, load a short program, run it to halt, then the halted cases
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{CMD_RESTART, 4'h0, 8'h00, 1'b1, RES_PC0},
		'{CMD_UNUSED,  4'hF, 8'hFF, 1'b1, RES_PC0},
		// li R1, 15
		'{CMD_LOAD, 4'h0, {OP_LI, 2'd1, 4'hF}, 1'b0, DERIVED},
		// add R2 = R0 + R1, wraps when R0 is 255
		'{CMD_LOAD, 4'h1, {OP_ADD, 2'd2, 2'd0, 2'd1}, 1'b0, DERIVED},
		// out R2 with the ignored bits set
		'{CMD_LOAD, 4'h2, {OP_OUT, 2'b11, 2'd2, 2'b11}, 1'b0, DERIVED},
		// bner0 R3 -> 5, taken
		'{CMD_LOAD, 4'h3, {OP_BNE, 4'd5, 2'd3}, 1'b0, DERIVED},
		'{CMD_LOAD, 4'h4, 8'hFF, 1'b1, RES_PC0},
		// bner0 R0 -> 15, never taken
		'{CMD_LOAD, 4'h5, {OP_BNE, 4'd15, 2'd0}, 1'b0, DERIVED},
		// bner0 R1 -> 15, taken
		'{CMD_LOAD, 4'h6, {OP_BNE, 4'd15, 2'd1}, 1'b0, DERIVED},
		// out R0 at the last address, then halt
		'{CMD_LOAD, 4'hF, {OP_OUT, 2'b00, 2'd0, 2'b00}, 1'b0, DERIVED},
		'{CMD_LOAD, 4'h7, 8'h00, 1'b1, RES_PC0},
		'{CMD_STEP, 4'h0, 8'h00, 1'b0, DERIVED},
		'{CMD_STEP, 4'hF, 8'hFF, 1'b0, DERIVED},
		'{CMD_STEP, 4'h0, 8'h00, 1'b0, DERIVED},
		'{CMD_STEP, 4'hA, 8'h5A, 1'b0, DERIVED},
		'{CMD_STEP, 4'h5, 8'hA5, 1'b0, DERIVED},
		'{CMD_STEP, 4'h0, 8'h00, 1'b0, DERIVED},
		'{CMD_STEP, 4'h0, 8'h00, 1'b1, RES_OUT_R0FF},
		'{CMD_STEP, 4'h0, 8'h00, 1'b1, RES_HALTED},
		'{CMD_UNUSED, 4'h0, 8'h00, 1'b1, RES_HALTED},
		'{CMD_LOAD, 4'hF, 8'hFF, 1'b1, RES_HALTED},
		'{CMD_RESTART, 4'hF, 8'hFF, 1'b1, RES_PC0}
	};

	four_register_eight_bit_cpu dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.load_address (load_address),
		.load_data    (load_data),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_valid    (out_valid),
		.out_index    (out_index),
		.out_value    (out_value),
		.next_address (next_address),
		.halted       (halted)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the processor by one item and return the result it reports
	function automatic cpu_result_t apply_item(input logic [1:0] cmd,
			input logic [3:0] addr, input logic [7:0] data);
		cpu_result_t r;
		logic [7:0] instr;
		logic [4:0] nxt;
		r = '0;
		case (cmd)
			CMD_LOAD: begin
				prog_mem[addr] = data;
				prog_written[addr] = 1'b1;
			end
			CMD_RESTART: begin
				for (int i = 0; i < RF_DEPTH; i++) gpr[i] = 8'h00;
				gpr[0] = start_val;
				pc = 5'd0;
			end
			CMD_STEP: begin
				if (pc < HALT_PC) begin
					instr = prog_mem[pc[3:0]];
					nxt = pc + 5'd1;
					case (instr[7:6])
						OP_ADD: gpr[instr[5:4]] = gpr[instr[3:2]] + gpr[instr[1:0]];
						OP_OUT: begin
							r.out_valid = 1'b1;
							r.out_index = instr[3:2];
							r.out_value = gpr[instr[3:2]];
						end
						OP_LI: gpr[instr[5:4]] = {4'h0, instr[3:0]};
						OP_BNE: begin
							if (gpr[0] != gpr[instr[1:0]]) nxt = {1'b0, instr[5:2]};
						end
					endcase
					pc = nxt;
				end
			end
			default: ;
		endcase
		r.next_address = pc;
		r.halted = (pc == HALT_PC);
		return r;
	endfunction

	// Offer one item, hold it until taken, then log its expected result
	task automatic send_item(input logic [1:0] cmd, input logic [3:0] addr,
			input logic [7:0] data, input logic typed, input cpu_result_t want);
		int gap;
		cpu_result_t pred;
		// never execute a store entry that was not written: write it instead
		if (cmd == CMD_STEP && pc != HALT_PC && !prog_written[pc[3:0]]) begin
			cmd = CMD_LOAD;
			addr = pc[3:0];
		end
		in_valid <= 1'b1;
		command <= cmd;
		load_address <= addr;
		load_data <= data;
		do @(posedge clk); while (in_ready !== 1'b1);
		pred = apply_item(cmd, addr, data);
		expected_q.push_back(typed ? want : pred);
		case (cmd)
			CMD_LOAD:    n_load++;
			CMD_RESTART: n_restart++;
			CMD_STEP:    n_step++;
			default:     n_unused++;
		endcase
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected result has been taken
	task automatic drain_results();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (expected_q.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (expected_q.size() != 0) begin
			failures++;
			$display("results stalled: %0d still expected", expected_q.size());
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_start_value(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		start_val = value;
		start_writes++;
	endtask

	// Load a program (whole store or a few bytes), restart, run it with some noise
	task automatic run_program();
		int n_steps;
		if ($urandom_range(0, 3) != 0) begin
			for (int k = 0; k < STORE_DEPTH; k++)
				send_item(CMD_LOAD, 4'(k), 8'($urandom), 1'b0, DERIVED);
		end else begin
			repeat ($urandom_range(1, 6))
				send_item(CMD_LOAD, 4'($urandom), 8'($urandom), 1'b0, DERIVED);
		end
		send_item(CMD_RESTART, 4'($urandom), 8'($urandom), 1'b0, DERIVED);
		n_steps = $urandom_range(4, 40);
		repeat (n_steps) begin
			case ($urandom_range(0, 19))
				0: send_item(CMD_LOAD, 4'($urandom), 8'($urandom), 1'b0, DERIVED);
				1: send_item(CMD_UNUSED, 4'($urandom), 8'($urandom), 1'b0, DERIVED);
				2: send_item(CMD_RESTART, 4'($urandom), 8'($urandom), 1'b0, DERIVED);
				default: send_item(CMD_STEP, 4'($urandom), 8'($urandom), 1'b0, DERIVED);
			endcase
		end
	endtask

	// Take results with random stalls and check each against the oldest expectation
	initial begin : result_sink
		int stall;
		cpu_result_t got;
		cpu_result_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_pending) begin
				stall = HOLD_CYCLES;
				hold_pending = 1'b0;
				holds_done++;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 5);
			end
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (res_valid !== 1'b1);
			got = {out_valid, out_index, out_value, next_address, halted};
			results_seen++;
			if (got.out_valid === 1'b1) out_reports++;
			if (got.halted === 1'b1) halted_seen++;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result %0d arrived with nothing expected", results_seen);
			end else begin
				want = expected_q.pop_front();
				if (got.out_valid !== want.out_valid || got.out_index !== want.out_index ||
						got.out_value !== want.out_value ||
						got.next_address !== want.next_address ||
						got.halted !== want.halted) begin
					failures++;
					if (failures <= 10) begin
						$display("result %0d: got out=%0b/%0d/%02h pc=%0d halt=%0b",
							results_seen, got.out_valid, got.out_index, got.out_value,
							got.next_address, got.halted);
						$display("  expected out=%0b/%0d/%02h pc=%0d halt=%0b",
							want.out_valid, want.out_index, want.out_value,
							want.next_address, want.halted);
					end
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases with different start values
	initial begin : stimulus
		int phase_base;
		bit hold_done;
		hold_done = 1'b0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			prog_mem[i] = 8'h00;
			prog_written[i] = 1'b0;
		end
		for (int i = 0; i < RF_DEPTH; i++) gpr[i] = 8'h00;
		pc = 5'd0;
		start_val = START_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_start_value(8'hFF);
		for (int r = 0; r < DIR_ROWS; r++)
			send_item(directed_rows[r].cmd, directed_rows[r].addr, directed_rows[r].data,
				directed_rows[r].typed, directed_rows[r].want);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_start_value(8'h00);
				1: write_start_value(8'($urandom_range(2, 254)));
				2: write_start_value(START_RESET);
				default: write_start_value(8'hFF);
			endcase
			// back-to-back traffic on both sides for one whole phase
			quiet = (ph == 2);
			phase_base = n_load + n_restart + n_step + n_unused;
			while (n_load + n_restart + n_step + n_unused - phase_base < PHASE_ITEMS) begin
				// stall the result side long enough to back up the input
				if (ph == 1 && !hold_done &&
						n_load + n_restart + n_step + n_unused - phase_base > 100) begin
					hold_pending = 1'b1;
					hold_done = 1'b1;
				end
				run_program();
			end
			drain_results();
		end

		failures += expected_q.size();
		$display("items: %0d loads, %0d restarts, %0d steps, %0d unused commands",
			n_load, n_restart, n_step, n_unused);
		$display("results: %0d checked, %0d out reports, %0d halted",
			results_seen, out_reports, halted_seen);
		$display("config: %0d start values, %0d long result holds",
			start_writes, holds_done);
		if (failures == 0) begin
			$display("four_register_eight_bit_cpu regression: pass");
		end else begin
			$display("%0d failures", failures);
			$display("four_register_eight_bit_cpu regression: fail");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#2_000_000;
		$display("four_register_eight_bit_cpu regression: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/frc_pkg.sv
design/frc_ctrl.sv
design/frc_dp.sv
design/four_register_eight_bit_cpu.sv
test/tb.sv
